/* hdl/tbc384_pkg.sv */
// Package for the 384-bit tweakey block cipher core.
// Holds S-boxes, GF(2^8) helpers, tweakey schedule steps, and shared types.
// No dependencies.
package tbc384_pkg;

  localparam int ROUNDS = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TK1_HI = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TK1_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TK2_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TK2_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TK3_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TK3_LO = 3'd5;

  localparam logic [7:0] RCON_INIT = 8'h2f;

  // Stage payload handed from cell to cell.
  typedef struct packed {
    logic         vld;
    logic         dec;
    logic [127:0] st;
  } stage_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t FWD_SUB = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam sbox_t INV_SUB = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  typedef logic [3:0] perm_t [16];
  localparam perm_t PERM_H = '{4'd1,4'd6,4'd11,4'd12,4'd5,4'd10,4'd15,4'd0,
                               4'd9,4'd14,4'd3,4'd4,4'd13,4'd2,4'd7,4'd8};

  // Byte k of a 128-bit value sits at bits [127-8k -: 8].
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int k);
    return v[127-8*k -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] permute_h(input logic [127:0] v);
    logic [127:0] o;
    for (int k = 0; k < 16; k++) o[127-8*k -: 8] = get_byte(v, int'(PERM_H[k]));
    return o;
  endfunction

  function automatic logic [127:0] lfsr2(input logic [127:0] v);
    logic [127:0] o;
    logic [7:0]   b;
    for (int k = 0; k < 16; k++) begin
      b = v[127-8*k -: 8];
      o[127-8*k -: 8] = {b[6:0], b[7] ^ b[5]};
    end
    return o;
  endfunction

  function automatic logic [127:0] lfsr3(input logic [127:0] v);
    logic [127:0] o;
    logic [7:0]   b;
    for (int k = 0; k < 16; k++) begin
      b = v[127-8*k -: 8];
      o[127-8*k -: 8] = {b[0] ^ b[6], b[7:1]};
    end
    return o;
  endfunction

  // Subtweakey from the current tweakey words and round constant.
  function automatic logic [127:0] subkey(input logic [127:0] a, input logic [127:0] b,
                                          input logic [127:0] c, input logic [7:0] rc);
    logic [127:0] s;
    s = a ^ b ^ c;
    for (int k = 0; k < 4; k++) begin
      s[127-8*k -: 8]     = s[127-8*k -: 8] ^ (8'd1 << k);
      s[127-8*(k+4) -: 8] = s[127-8*(k+4) -: 8] ^ rc;
    end
    return s;
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int col = 0; col < 4; col++)
      for (int row = 0; row < 4; row++) begin
        if (!inv)
          o[127-8*(col*4+row) -: 8] = FWD_SUB[get_byte(s, ((col+row) & 3)*4 + row)];
        else
          o[127-8*(col*4+row) -: 8] = INV_SUB[get_byte(s, ((col-row) & 3)*4 + row)];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3;
    for (int col = 0; col < 4; col++) begin
      a0 = get_byte(s, col*4);
      a1 = get_byte(s, col*4+1);
      a2 = get_byte(s, col*4+2);
      a3 = get_byte(s, col*4+3);
      o[127-8*(col*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      o[127-8*(col*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      o[127-8*(col*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      o[127-8*(col*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return o;
  endfunction

  // Inverse mix: pre-multiply by {04,05} form, then forward mix.
  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] p;
    logic [7:0]   a0, a1, a2, a3, u, v;
    for (int col = 0; col < 4; col++) begin
      a0 = get_byte(s, col*4);
      a1 = get_byte(s, col*4+1);
      a2 = get_byte(s, col*4+2);
      a3 = get_byte(s, col*4+3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      p[127-8*(col*4)   -: 8] = a0 ^ u;
      p[127-8*(col*4+1) -: 8] = a1 ^ v;
      p[127-8*(col*4+2) -: 8] = a2 ^ u;
      p[127-8*(col*4+3) -: 8] = a3 ^ v;
    end
    return mix_fwd(p);
  endfunction

endpackage

/* hdl/tbc384_cell.sv */
// One round cell of the cipher chain: forward or inverse round, registered.
// Depends on tbc384_pkg.
module tbc384_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tbc384_pkg::stage_t     stg_in,
  input  logic [127:0]           key_enc,
  input  logic [127:0]           key_dec,
  output tbc384_pkg::stage_t     stg_out
);

  logic         vld_r;
  logic         dec_r;
  logic [127:0] st_r;
  logic [127:0] st_nxt;
  logic [127:0] enc_v;
  logic [127:0] dec_v;

  always_comb begin
    enc_v  = tbc384_pkg::mix_fwd(tbc384_pkg::sub_shift(stg_in.st ^ key_enc, 1'b0));
    dec_v  = tbc384_pkg::sub_shift(tbc384_pkg::mix_inv(stg_in.st ^ key_dec), 1'b1);
    st_nxt = stg_in.dec ? dec_v : enc_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= stg_in.vld;
    end
    dec_r <= stg_in.dec;
    st_r  <= st_nxt;
  end

  assign stg_out = '{vld: vld_r, dec: dec_r, st: st_r};

endmodule

/* hdl/tbc384_keysched.sv */
// Round tweakey store: computes all subtweakeys from the tweakey registers.
// A chain of schedule cells, each registered, followed by a registered subtweakey output.
// Depends on tbc384_pkg.
module tbc384_keysched (
  input  logic                       clk,
  input  logic [127:0]               tk1,
  input  logic [127:0]               tk2,
  input  logic [127:0]               tk3,
  output logic [tbc384_pkg::ROUNDS:0][127:0] sk
);

  logic [tbc384_pkg::ROUNDS:0][127:0] a_r, b_r, c_r;
  logic [tbc384_pkg::ROUNDS:0][7:0]   rc_r;

  // Each cell derives its words from its left neighbor, one per cycle.
  always_ff @(posedge clk) begin
    a_r[0]  <= tk1;
    b_r[0]  <= tk2;
    c_r[0]  <= tk3;
    rc_r[0] <= tbc384_pkg::RCON_INIT;
    for (int r = 1; r <= tbc384_pkg::ROUNDS; r++) begin
      a_r[r]  <= tbc384_pkg::permute_h(a_r[r-1]);
      b_r[r]  <= tbc384_pkg::lfsr2(tbc384_pkg::permute_h(b_r[r-1]));
      c_r[r]  <= tbc384_pkg::lfsr3(tbc384_pkg::permute_h(c_r[r-1]));
      rc_r[r] <= tbc384_pkg::xt(rc_r[r-1]);
    end
    for (int r = 0; r <= tbc384_pkg::ROUNDS; r++)
      sk[r] <= tbc384_pkg::subkey(a_r[r], b_r[r], c_r[r], rc_r[r]);
  end

endmodule

/* hdl/tweakable_block_cipher_384_core.sv */
// Top level of the 384-bit tweakey block cipher core.
// Instantiates tbc384_keysched and a chain of tbc384_cell; uses tbc384_pkg.
//
//  channel | signals                              | transfer when
//  --------+--------------------------------------+---------------------------
//  input   | start, busy, in_func, in_block_hi/lo | start && !busy
//  result  | out_valid, out_result_hi/lo          | out_valid (one cycle)
//  config  | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
// A block enters every cycle; busy stays low. Each block passes through
// sixteen round cells and one output register that drives the result
// ports. The subtweakey chain settles through its registers after a config
// write; the user must see that config is written only while idle, as the
// block itself does not enforce it. Synchronous active-low reset clears the
// valid bits and tweakey registers. The receiver cannot stall.
module tweakable_block_cipher_384_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tbc384_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int R = tbc384_pkg::ROUNDS;

  logic [63:0] tk1_hi_r, tk1_lo_r, tk2_hi_r, tk2_lo_r, tk3_hi_r, tk3_lo_r;
  logic [R:0][127:0] sk;
  tbc384_pkg::stage_t stg [R+1];
  logic         ov_r;
  logic [127:0] res_r;
  logic [127:0] res_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Tweakey registers; ignore indexes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tk1_hi_r <= '0; tk1_lo_r <= '0;
      tk2_hi_r <= '0; tk2_lo_r <= '0;
      tk3_hi_r <= '0; tk3_lo_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbc384_pkg::REG_TK1_HI: tk1_hi_r <= cfg_data;
        tbc384_pkg::REG_TK1_LO: tk1_lo_r <= cfg_data;
        tbc384_pkg::REG_TK2_HI: tk2_hi_r <= cfg_data;
        tbc384_pkg::REG_TK2_LO: tk2_lo_r <= cfg_data;
        tbc384_pkg::REG_TK3_HI: tk3_hi_r <= cfg_data;
        tbc384_pkg::REG_TK3_LO: tk3_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tbc384_keysched u_ks (
    .clk (clk),
    .tk1 ({tk1_hi_r, tk1_lo_r}),
    .tk2 ({tk2_hi_r, tk2_lo_r}),
    .tk3 ({tk3_hi_r, tk3_lo_r}),
    .sk  (sk)
  );

  assign stg[0] = '{vld: start, dec: in_func, st: {in_block_hi, in_block_lo}};

  // Cell i runs encrypt round i or decrypt round for subtweakey R-i.
  for (genvar i = 0; i < R; i++) begin : g_cell
    tbc384_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stg_in  (stg[i]),
      .key_enc (sk[i]),
      .key_dec (sk[R-i]),
      .stg_out (stg[i+1])
    );
  end

  // Final whitening: add the last subtweakey for the direction taken.
  assign res_nxt = stg[R].st ^ (stg[R].dec ? sk[0] : sk[R]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= stg[R].vld;
    end
    res_r <= res_nxt;
  end

  assign out_valid     = ov_r;
  assign out_result_hi = res_r[127:64];
  assign out_result_lo = res_r[63:0];

endmodule
